>>> design/sxf_pkg.sv
package sxf_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // kinds of a result item
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // field widths
    localparam int OP_W     = 2;
    localparam int POS_W    = 8;
    localparam int ROFF_W   = 4;
    localparam int SPRITE_W = 8;
    localparam int KIND_W   = 2;
    localparam int PIX_W    = 64;

    // default screen geometry
    localparam int DEF_SCREEN_COLS = 64;
    localparam int DEF_SCREEN_ROWS = 32;

    // fixed-point scale of the reciprocals used for the wrap-around
    localparam int RECIP_SHIFT = 16;

endpackage

>>> design/sxf_ram.sv
module sxf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/sprite_xor_framebuffer.sv
// One-bit display store of SCREEN_ROWS rows by SCREEN_COLS columns, one row per
// memory word, column 0 in the top bit. A draw item XORs eight sprite pixels into row
// (y_pos + row_offset) mod SCREEN_ROWS starting at column x_pos mod SCREEN_COLS,
// wrapping at the right edge, and sets a sticky collision flag when a lit pixel goes
// dark; row_offset 0 restarts the flag and an item with last_row set returns it.
// A read item returns the first 64 columns of row y_pos mod SCREEN_ROWS. A clear
// item blanks the screen in one step through per-row valid bits. Every item reads its
// row from the row memory on acceptance, then in ST_MODIFY modifies it and, for a draw,
// writes it back. The next item is taken while a result waits on the m_ side; a new result
// waits for that slot to empty. Operation code 3 is dropped with no result.
module sprite_xor_framebuffer #(
    parameter int SCREEN_COLS = sxf_pkg::DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = sxf_pkg::DEF_SCREEN_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sxf_pkg::OP_W-1:0]      s_operation,
    input  logic [sxf_pkg::POS_W-1:0]     s_x_pos,
    input  logic [sxf_pkg::POS_W-1:0]     s_y_pos,
    input  logic [sxf_pkg::ROFF_W-1:0]    s_row_offset,
    input  logic [sxf_pkg::SPRITE_W-1:0]  s_sprite_byte,
    input  logic                          s_last_row,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_collision,
    output logic [sxf_pkg::PIX_W-1:0]     m_row_pixels,
    output logic [sxf_pkg::KIND_W-1:0]    m_result_kind
);

    import sxf_pkg::*;

    localparam int COL_W   = $clog2(SCREEN_COLS);
    localparam int ROW_W   = $clog2(SCREEN_ROWS);
    localparam int SUM_W   = POS_W + 1;
    localparam int RECIP_W = RECIP_SHIFT + 1;
    localparam int COL_RECIP = (1 << RECIP_SHIFT) / SCREEN_COLS;
    localparam int ROW_RECIP = (1 << RECIP_SHIFT) / SCREEN_ROWS;
    localparam int PROD_W  = SUM_W + RECIP_W;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_MODIFY = 2'b10
    } state_t;

    // column wrap: reciprocal estimate, then one correcting subtract
    function automatic logic [COL_W-1:0] wrap_col(input logic [POS_W-1:0] val);
        logic [PROD_W-1:0] prod;
        logic [SUM_W-1:0]  quot;
        logic [2*SUM_W-1:0] qc;
        logic [SUM_W-1:0]  rem;
        prod = PROD_W'(val) * PROD_W'(COL_RECIP);
        quot = prod[RECIP_SHIFT +: SUM_W];
        qc   = (2*SUM_W)'(quot) * (2*SUM_W)'(SCREEN_COLS);
        rem  = SUM_W'(val) - qc[SUM_W-1:0];
        if (rem >= SUM_W'(SCREEN_COLS)) begin
            rem = rem - SUM_W'(SCREEN_COLS);
        end
        return rem[COL_W-1:0];
    endfunction

    // row wrap, same scheme on the wider row sum
    function automatic logic [ROW_W-1:0] wrap_row(input logic [SUM_W-1:0] val);
        logic [PROD_W-1:0] prod;
        logic [SUM_W-1:0]  quot;
        logic [2*SUM_W-1:0] qc;
        logic [SUM_W-1:0]  rem;
        prod = PROD_W'(val) * PROD_W'(ROW_RECIP);
        quot = prod[RECIP_SHIFT +: SUM_W];
        qc   = (2*SUM_W)'(quot) * (2*SUM_W)'(SCREEN_ROWS);
        rem  = val - qc[SUM_W-1:0];
        if (rem >= SUM_W'(SCREEN_ROWS)) begin
            rem = rem - SUM_W'(SCREEN_ROWS);
        end
        return rem[ROW_W-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [OP_W-1:0]       op_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      col_reg;
    logic [SPRITE_W-1:0]   sprite_reg;
    logic                  last_reg;
    logic                  restart_reg;
    logic                  erase_seen_reg, erase_seen_next;
    logic [SCREEN_ROWS-1:0] row_valid_reg, row_valid_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_collision_reg, m_collision_next;
    logic [PIX_W-1:0]      m_pixels_reg, m_pixels_next;
    logic [KIND_W-1:0]     m_kind_reg, m_kind_next;

    logic                  accept;
    logic [SUM_W-1:0]      row_sum;
    logic [ROW_W-1:0]      row_addr;
    logic [SCREEN_COLS-1:0] ram_rdata;
    logic [SCREEN_COLS-1:0] cur_row;
    logic [SCREEN_COLS-1:0] draw_mask;
    logic [SCREEN_COLS-1:0] new_row;
    logic [PIX_W-1:0]      read_pix;
    logic                  erased;
    logic                  out_needed;
    logic                  mod_go;
    logic                  ram_we;

    // input side: one item at a time, read issued on acceptance
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign row_sum = (s_operation == OP_DRAW)
                   ? SUM_W'(s_y_pos) + SUM_W'(s_row_offset)
                   : SUM_W'(s_y_pos);
    assign row_addr = wrap_row(row_sum);

    sxf_ram #(
        .WIDTH (SCREEN_COLS),
        .DEPTH (SCREEN_ROWS)
    ) u_row_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (new_row),
        .re    (accept),
        .raddr (row_addr),
        .rdata (ram_rdata)
    );

    // a row not written since the last clear reads as blank
    assign cur_row = row_valid_reg[row_reg] ? ram_rdata : '0;

    // sprite pixels placed on the row, wrapping at the right edge
    always_comb begin
        logic [COL_W:0]   col;
        logic [COL_W-1:0] idx;
        draw_mask = '0;
        for (int k = 0; k < SPRITE_W; k++) begin
            col = (COL_W+1)'(col_reg) + (COL_W+1)'(k);
            if (col >= (COL_W+1)'(SCREEN_COLS)) begin
                col = col - (COL_W+1)'(SCREEN_COLS);
            end
            idx = COL_W'(SCREEN_COLS - 1) - col[COL_W-1:0];
            draw_mask[idx] = sprite_reg[SPRITE_W-1-k];
        end
    end

    assign new_row = cur_row ^ draw_mask;
    assign erased  = |(cur_row & draw_mask);

    // display row: first 64 columns, columns past the screen read as zero
    for (genvar c = 0; c < PIX_W; c++) begin : g_read_pix
        if (c < SCREEN_COLS) begin : g_col
            assign read_pix[PIX_W-1-c] = cur_row[SCREEN_COLS-1-c];
        end else begin : g_pad
            assign read_pix[PIX_W-1-c] = 1'b0;
        end
    end

    // finish the item once the result slot is free, or at once if it gives no result
    assign out_needed = (op_reg == OP_CLEAR) || (op_reg == OP_READ)
                     || ((op_reg == OP_DRAW) && last_reg);
    assign mod_go = (state_reg == ST_MODIFY)
                 && (!out_needed || !m_valid_reg || m_ready);
    assign ram_we = mod_go && (op_reg == OP_DRAW);

    // next-state logic
    always_comb begin
        logic seen;
        state_next       = state_reg;
        erase_seen_next  = erase_seen_reg;
        row_valid_next   = row_valid_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_collision_next = m_collision_reg;
        m_pixels_next    = m_pixels_reg;
        m_kind_next      = m_kind_reg;
        seen             = (erase_seen_reg && !restart_reg) || erased;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                if (mod_go) begin
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_CLEAR: begin
                            row_valid_next   = '0;
                            m_valid_next     = 1'b1;
                            m_collision_next = 1'b0;
                            m_pixels_next    = '0;
                            m_kind_next      = KIND_CLEAR;
                        end
                        OP_DRAW: begin
                            erase_seen_next         = seen;
                            row_valid_next[row_reg] = 1'b1;
                            if (last_reg) begin
                                m_valid_next     = 1'b1;
                                m_collision_next = seen;
                                m_pixels_next    = '0;
                                m_kind_next      = KIND_DRAW;
                            end
                        end
                        OP_READ: begin
                            m_valid_next     = 1'b1;
                            m_collision_next = 1'b0;
                            m_pixels_next    = read_pix;
                            m_kind_next      = KIND_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            erase_seen_reg <= 1'b0;
            row_valid_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            erase_seen_reg <= erase_seen_next;
            row_valid_reg  <= row_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= s_operation;
            row_reg     <= row_addr;
            col_reg     <= wrap_col(s_x_pos);
            sprite_reg  <= s_sprite_byte;
            last_reg    <= s_last_row;
            restart_reg <= (s_row_offset == '0);
        end
        m_collision_reg <= m_collision_next;
        m_pixels_reg    <= m_pixels_next;
        m_kind_reg      <= m_kind_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_collision   = m_collision_reg;
    assign m_row_pixels  = m_pixels_reg;
    assign m_result_kind = m_kind_reg;

endmodule

>>> tb/sv/sprite_xor_framebuffer_tb.sv
`timescale 1ns / 1ps

module sprite_xor_framebuffer_tb;

    import sxf_pkg::*;

    localparam int SCREEN_COLS  = DEF_SCREEN_COLS;
    localparam int SCREEN_ROWS  = DEF_SCREEN_ROWS;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1500;
    localparam int LONG_HOLD    = 300;
    localparam int STUCK_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 16;

    // one expected result item
    typedef struct packed {
        logic              collision;
        logic [PIX_W-1:0]  row_pixels;
        logic [KIND_W-1:0] result_kind;
    } screen_result_t;

    // shadow of the display store and the collision flag, plus pending results
    class sprite_scoreboard;
        logic [PIX_W-1:0] screen [SCREEN_ROWS];
        bit               pixel_erased;
        screen_result_t   expected_q [$];
        int               failures;

        function new();
            foreach (screen[r]) screen[r] = '0;
            pixel_erased = 1'b0;
            failures = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // apply an accepted item to the shadow store and queue its result
        function void note_item(logic [OP_W-1:0] op, logic [POS_W-1:0] x,
                                logic [POS_W-1:0] y, logic [ROFF_W-1:0] roff,
                                logic [SPRITE_W-1:0] pixels, logic last);
            screen_result_t res;
            int row;
            int col;
            logic was_lit;
            logic pix;
            res = '0;
            case (op)
                OP_CLEAR: begin
                    foreach (screen[r]) screen[r] = '0;
                    res.result_kind = KIND_CLEAR;
                    expected_q.push_back(res);
                end
                OP_DRAW: begin
                    row = (int'(y) + int'(roff)) % SCREEN_ROWS;
                    if (roff == '0) pixel_erased = 1'b0;
                    for (int k = 0; k < SPRITE_W; k++) begin
                        col = (int'(x) + k) % SCREEN_COLS;
                        pix = pixels[SPRITE_W-1-k];
                        was_lit = screen[row][PIX_W-1-col];
                        if (was_lit && pix) pixel_erased = 1'b1;
                        screen[row][PIX_W-1-col] = was_lit ^ pix;
                    end
                    if (last) begin
                        res.collision = pixel_erased;
                        res.result_kind = KIND_DRAW;
                        expected_q.push_back(res);
                    end
                end
                OP_READ: begin
                    res.row_pixels = screen[int'(y) % SCREEN_ROWS];
                    res.result_kind = KIND_READ;
                    expected_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        // compare a delivered result with the oldest pending one
        function void check_result(logic coll, logic [PIX_W-1:0] pix,
                                   logic [KIND_W-1:0] kind);
            screen_result_t exp_res;
            if (expected_q.size() == 0) begin
                $error("unexpected result item: kind %0d", kind);
                failures++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (kind !== exp_res.result_kind) begin
                $error("result_kind mismatch: expected %0d, actual %0d",
                       exp_res.result_kind, kind);
                failures++;
            end
            if (coll !== exp_res.collision) begin
                $error("collision mismatch: expected %0d, actual %0d",
                       exp_res.collision, coll);
                failures++;
            end
            if (pix !== exp_res.row_pixels) begin
                $error("row_pixels mismatch: expected %016h, actual %016h",
                       exp_res.row_pixels, pix);
                failures++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation;
    logic [POS_W-1:0]    s_x_pos;
    logic [POS_W-1:0]    s_y_pos;
    logic [ROFF_W-1:0]   s_row_offset;
    logic [SPRITE_W-1:0] s_sprite_byte;
    logic                s_last_row;
    logic                m_valid;
    logic                m_ready;
    logic                m_collision;
    logic [PIX_W-1:0]    m_row_pixels;
    logic [KIND_W-1:0]   m_result_kind;

    sprite_scoreboard sb = new();

    bit quiet_stretch;
    bit hold_request;
    int items_sent;

    // current sprite, kept so it can be drawn again to erase itself
    logic [POS_W-1:0]    sprite_x;
    logic [POS_W-1:0]    sprite_y;
    int                  sprite_rows;
    logic [SPRITE_W-1:0] sprite_bytes [16];

    sprite_xor_framebuffer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_x_pos       (s_x_pos),
        .s_y_pos       (s_y_pos),
        .s_row_offset  (s_row_offset),
        .s_sprite_byte (s_sprite_byte),
        .s_last_row    (s_last_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_collision   (m_collision),
        .m_row_pixels  (m_row_pixels),
        .m_result_kind (m_result_kind)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // offer one item, with random idle cycles ahead of it outside quiet stretches, and wait for acceptance
    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [ROFF_W-1:0] roff,
                             input logic [SPRITE_W-1:0] pixels, input logic last);
        while (!quiet_stretch && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_x_pos       <= x;
        s_y_pos       <= y;
        s_row_offset  <= roff;
        s_sprite_byte <= pixels;
        s_last_row    <= last;
        do @(posedge aclk); while (!s_ready);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // draw the current sprite row by row as one well-formed sequence
    task automatic plot_sprite();
        for (int r = 0; r < sprite_rows; r++)
            send_item(OP_DRAW, sprite_x, sprite_y, ROFF_W'(r), sprite_bytes[r],
                      r == sprite_rows - 1);
    endtask

    // receiver: random stalls, long hold-offs whenever requested
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_ready <= (!quiet_stretch && $urandom_range(99) < 20) ? 1'b0 : 1'b1;
            end
        end
    end

    // monitor: check delivered results, then note accepted items
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_collision, m_row_pixels, m_result_kind);
            if (s_valid && s_ready)
                sb.note_item(s_operation, s_x_pos, s_y_pos, s_row_offset,
                             s_sprite_byte, s_last_row);
        end
    end

    // watchdog on cycles with no handshake on either side
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stuck = 0;
            else stuck++;
        end
        $display("simulation failed");
        $finish;
    end

    // stimulus
    initial begin
        int pick;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_operation   <= OP_CLEAR;
        s_x_pos       <= '0;
        s_y_pos       <= '0;
        s_row_offset  <= '0;
        s_sprite_byte <= '0;
        s_last_row    <= 1'b0;
        quiet_stretch = 1'b0;
        hold_request  = 1'b0;
        items_sent    = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty read, overlap collision, wrap on both axes, ignored code
        send_item(OP_READ,   8'h00, 8'h00, 4'h0, 8'h00, 1'b0);
        send_item(OP_DRAW,   8'h00, 8'h00, 4'h0, 8'hFF, 1'b0);
        send_item(OP_DRAW,   8'h00, 8'h00, 4'h1, 8'h80, 1'b1);
        send_item(OP_READ,   8'h00, 8'h00, 4'h0, 8'h00, 1'b0);
        send_item(OP_READ,   8'h00, 8'h01, 4'h0, 8'h00, 1'b0);
        send_item(OP_DRAW,   8'h00, 8'h00, 4'h0, 8'h0F, 1'b1);
        send_item(OP_DRAW,   8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1);
        send_item(OP_READ,   8'h00, 8'hEE, 4'h0, 8'h00, 1'b0);
        send_item(OP_DRAW,   8'h3C, 8'h1F, 4'h0, 8'hAA, 1'b1);
        send_item(OP_READ,   8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1);
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1);
        send_item(OP_UNUSED, 8'h00, 8'h00, 4'h0, 8'h00, 1'b0);
        send_item(OP_DRAW,   8'h10, 8'h03, 4'h0, 8'h00, 1'b1);
        send_item(OP_DRAW,   8'hAA, 8'h55, 4'h5, 8'h55, 1'b0);
        send_item(OP_DRAW,   8'h55, 8'hAA, 4'hA, 8'hAA, 1'b1);
        send_item(OP_READ,   8'h00, 8'h1A, 4'h0, 8'h00, 1'b0);
        send_item(OP_CLEAR,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0);
        send_item(OP_READ,   8'h00, 8'h00, 4'h0, 8'h00, 1'b0);
        send_item(OP_READ,   8'h00, 8'h0E, 4'h0, 8'h00, 1'b0);
        send_item(OP_DRAW,   8'h08, 8'h04, 4'h3, 8'hC3, 1'b1);
        send_item(OP_DRAW,   8'h00, 8'h00, 4'h0, 8'h80, 1'b1);
        send_item(OP_DRAW,   8'h00, 8'h00, 4'h0, 8'h80, 1'b1);
        send_item(OP_READ,   8'h00, 8'h00, 4'h0, 8'h00, 1'b0);

        // random: mostly whole sprites, some redraws, reads, stray rows and noise
        items_sent  = 0;
        sprite_rows = 0;
        while (items_sent < RANDOM_ITEMS) begin
            quiet_stretch = (items_sent >= 700 && items_sent < 1000);
            if (items_sent >= 400 && items_sent < 410) hold_request = 1'b1;
            pick = $urandom_range(99);
            if (pick < 55 || sprite_rows == 0) begin
                sprite_x    = POS_W'($urandom_range(255));
                sprite_y    = POS_W'($urandom_range(255));
                sprite_rows = $urandom_range(1, 16);
                foreach (sprite_bytes[i]) sprite_bytes[i] = SPRITE_W'($urandom_range(255));
                plot_sprite();
            end else if (pick < 65) begin
                plot_sprite();
            end else if (pick < 80) begin
                send_item(OP_READ, POS_W'($urandom_range(255)), POS_W'($urandom_range(255)),
                          ROFF_W'($urandom_range(15)), SPRITE_W'($urandom_range(255)),
                          1'($urandom_range(1)));
            end else if (pick < 93) begin
                send_item(OP_DRAW, POS_W'($urandom_range(255)), POS_W'($urandom_range(255)),
                          ROFF_W'($urandom_range(15)), SPRITE_W'($urandom_range(255)),
                          1'($urandom_range(1)));
            end else if (pick < 98) begin
                send_item(OP_UNUSED, POS_W'($urandom_range(255)), POS_W'($urandom_range(255)),
                          ROFF_W'($urandom_range(15)), SPRITE_W'($urandom_range(255)),
                          1'($urandom_range(1)));
            end else begin
                send_item(OP_CLEAR, POS_W'($urandom_range(255)), POS_W'($urandom_range(255)),
                          ROFF_W'($urandom_range(15)), SPRITE_W'($urandom_range(255)),
                          1'($urandom_range(1)));
            end
        end
        quiet_stretch = 1'b0;
        s_valid <= 1'b0;

        // drain outstanding results, then wait out the drain period and check that none remain
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d expected result items never arrived", sb.pending());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
design/sxf_pkg.sv
design/sxf_ram.sv
design/sprite_xor_framebuffer.sv
tb/sv/sprite_xor_framebuffer_tb.sv
